>>> hdl/pps_pkg.sv
// Package for the pure-pursuit steering block: payload structs, register
// indices, reset values, CORDIC constants and arctangent table.
// No dependencies.
`default_nettype none

package pps_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_SPEED = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SPEED_DIV = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LA_MIN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LA_MAX = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WHEELBASE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_AXLE_OFFSET = 3'd5;

  localparam logic [7:0] SPEED_RST = 8'd50;
  localparam logic [7:0] SPEED_DIV_RST = 8'd5;
  localparam logic [6:0] LA_MIN_RST = 7'd5;
  localparam logic [6:0] LA_MAX_RST = 7'd10;
  localparam logic [14:0] WHEELBASE_RST = 15'd256;
  localparam logic signed [15:0] AXLE_OFFSET_RST = 16'sd435;

  // CORDIC datapath widths
  localparam int unsigned CordW = 52;
  localparam int unsigned AngW = 20;
  localparam logic signed [CordW-1:0] CORDIC_KINV = 52'sd652032874;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_point;
  } pps_in_t;

  typedef struct packed {
    logic signed [15:0] steering;
    logic               found;
  } pps_out_t;

  // atan(2^-i) in radians * 2^16
  function automatic logic signed [AngW-1:0] atan_lut(input logic [3:0] idx);
    logic signed [AngW-1:0] v;
    unique case (idx)
      4'd0:    v = 20'sd51472;
      4'd1:    v = 20'sd30386;
      4'd2:    v = 20'sd16055;
      4'd3:    v = 20'sd8150;
      4'd4:    v = 20'sd4091;
      4'd5:    v = 20'sd2047;
      4'd6:    v = 20'sd1024;
      4'd7:    v = 20'sd512;
      4'd8:    v = 20'sd256;
      4'd9:    v = 20'sd128;
      4'd10:   v = 20'sd64;
      4'd11:   v = 20'sd32;
      4'd12:   v = 20'sd16;
      4'd13:   v = 20'sd8;
      4'd14:   v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/pure_pursuit_steering.sv
// Pure-pursuit steering: lookahead search over a waypoint scan and steering
// angle by a shared CORDIC unit, one multiplier and a small divider.
// Depends on pps_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one waypoint
//   per transfer; last_point marks the end of a scan. Only the last point of
//   a scan produces a result on the output channel (out_valid_o / out_stall_i
//   / out_data_o): steering in Q3.13 radians and the found flag.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are taken at any time;
//   indices above 5 are ignored. Write them only while the block is idle.
//   Sequence: each point runs the speed/divisor divider, a clamp step, three
//   multiplier steps for a candidate point while no target is held, and a
//   decide step; no new point is taken before the decide step ends. The last
//   point of a scan with a target adds three 16-iteration CORDIC passes and a
//   multiply before its result appears; an arctangent pass is skipped for a
//   zero operand.
//   Reset restores the default registers and clears the search; no clearing
//   pass is needed. A result held by out_stall_i stays in the output
//   register; a further point may be taken meanwhile, and the block waits
//   before its own result until the register is free.
`default_nettype none

module pure_pursuit_steering
  import pps_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire pps_in_t            in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      pps_out_t           out_data_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_SQX,
    ST_SQY,
    ST_CMP,
    ST_DECIDE,
    ST_ATAN1,
    ST_SIN,
    ST_MULW,
    ST_ATAN2,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [7:0]         speed_q, sdiv_q;
  logic [6:0]         la_min_q, la_max_q;
  logic [14:0]        wb_q;
  logic signed [15:0] axle_q;

  // item and search state
  logic signed [15:0] px_q, py_q;
  logic               last_q;
  logic               tfound_q;
  logic signed [16:0] tdx_q;
  logic signed [15:0] tdy_q;
  logic [6:0]         la_q;

  // divider
  logic [7:0] rem_q, quo_q, dvs_q;
  logic [3:0] cnt_q;

  // shared units
  logic [34:0]             acc_q;
  logic signed [31:0]      sin_q;
  logic signed [CordW-1:0] cx_q, cy_q;
  logic signed [AngW-1:0]  cz_q;

  logic     out_valid_q;
  pps_out_t out_data_q;

  logic in_xfer, out_xfer, emit;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_q && !out_stall_i;
  assign emit     = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // divider step
  logic [8:0] div_sh;
  logic       div_ge;
  logic [8:0] div_diff;
  assign div_sh   = {rem_q, quo_q[7]};
  assign div_ge   = (div_sh >= {1'b0, dvs_q});
  assign div_diff = div_sh - {1'b0, dvs_q};

  // clamp
  logic [6:0] la_clamp;
  always_comb begin
    priority if (quo_q < {1'b0, la_min_q}) begin
      la_clamp = la_min_q;
    end else if (quo_q > {1'b0, la_max_q}) begin
      la_clamp = la_max_q;
    end else begin
      la_clamp = quo_q[6:0];
    end
  end

  logic signed [16:0] dx;
  logic               dx_pos;
  assign dx     = $signed({px_q[15], px_q}) - $signed({axle_q[15], axle_q});
  assign dx_pos = !dx[16] && (dx != 17'sd0);

  // shared multiplier
  logic signed [16:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [48:0] prod;
  always_comb begin
    unique case (state_q)
      ST_SQX: begin
        mul_a = dx;
        mul_b = {{15{dx[16]}}, dx};
      end
      ST_SQY: begin
        mul_a = {py_q[15], py_q};
        mul_b = {{16{py_q[15]}}, py_q};
      end
      ST_CMP: begin
        mul_a = {10'd0, la_q};
        mul_b = {25'd0, la_q};
      end
      ST_MULW: begin
        mul_a = {2'b00, wb_q};
        mul_b = sin_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  logic hit;
  assign hit = (acc_q >= {5'd0, prod[13:0], 16'd0});

  logic signed [CordW-1:0] num;
  assign num = {{2{prod[48]}}, prod, 1'b0};

  // shared CORDIC step
  logic signed [CordW-1:0] xs, ys, cx_nx, cy_nx;
  logic signed [AngW-1:0]  cz_nx, ang;
  logic                    sigma;
  assign xs    = cx_q >>> cnt_q;
  assign ys    = cy_q >>> cnt_q;
  assign ang   = atan_lut(cnt_q);
  assign sigma = (state_q == ST_SIN) ? cz_q[AngW-1] : !cy_q[CordW-1];
  assign cx_nx = sigma ? cx_q + ys : cx_q - ys;
  assign cy_nx = sigma ? cy_q - xs : cy_q + xs;
  assign cz_nx = sigma ? cz_q + ang : cz_q - ang;

  // Q.16 to Q3.13, half away from zero
  logic [AngW-1:0]    mag;
  logic [AngW-1:0]    rnd;
  logic signed [15:0] steer;
  assign mag   = cz_q[AngW-1] ? AngW'(-cz_q) : AngW'(cz_q);
  assign rnd   = (mag + AngW'(4)) >> 3;
  assign steer = cz_q[AngW-1] ? 16'(-rnd) : 16'(rnd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= SPEED_RST;
      sdiv_q   <= SPEED_DIV_RST;
      la_min_q <= LA_MIN_RST;
      la_max_q <= LA_MAX_RST;
      wb_q     <= WHEELBASE_RST;
      axle_q   <= AXLE_OFFSET_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SPEED:       speed_q  <= cfg_data_i[7:0];
        REG_SPEED_DIV:   sdiv_q   <= cfg_data_i[7:0];
        REG_LA_MIN:      la_min_q <= cfg_data_i[6:0];
        REG_LA_MAX:      la_max_q <= cfg_data_i[6:0];
        REG_WHEELBASE:   wb_q     <= cfg_data_i[14:0];
        REG_AXLE_OFFSET: axle_q   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tfound_q    <= 1'b0;
      tdx_q       <= '0;
      tdy_q       <= '0;
      la_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            px_q    <= in_data_i.point_x;
            py_q    <= in_data_i.point_y;
            last_q  <= in_data_i.last_point;
            rem_q   <= '0;
            quo_q   <= speed_q;
            dvs_q   <= (sdiv_q == 8'd0) ? 8'd1 : sdiv_q;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= div_ge ? div_diff[7:0] : div_sh[7:0];
          quo_q <= {quo_q[6:0], div_ge};
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd7) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          la_q    <= la_clamp;
          state_q <= (!tfound_q && dx_pos) ? ST_SQX : ST_DECIDE;
        end
        ST_SQX: begin
          acc_q   <= prod[34:0];
          state_q <= ST_SQY;
        end
        ST_SQY: begin
          acc_q   <= acc_q + prod[34:0];
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (hit) begin
            tfound_q <= 1'b1;
            tdx_q    <= dx;
            tdy_q    <= py_q;
          end
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          cnt_q <= '0;
          cz_q  <= '0;
          priority if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (!tfound_q) begin
            state_q <= ST_DONE;
          end else if (tdy_q == 16'sd0) begin
            cx_q    <= CORDIC_KINV;
            cy_q    <= '0;
            state_q <= ST_SIN;
          end else begin
            cx_q    <= {{21{tdx_q[16]}}, tdx_q, 14'd0};
            cy_q    <= {{22{tdy_q[15]}}, tdy_q, 14'd0};
            state_q <= ST_ATAN1;
          end
        end
        ST_ATAN1: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            cx_q    <= CORDIC_KINV;
            cy_q    <= '0;
            cz_q    <= cz_nx;
            state_q <= ST_SIN;
          end else begin
            cx_q <= cx_nx;
            cy_q <= cy_nx;
            cz_q <= cz_nx;
          end
        end
        ST_SIN: begin
          cx_q  <= cx_nx;
          cy_q  <= cy_nx;
          cz_q  <= cz_nx;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            sin_q   <= cy_nx[31:0];
            state_q <= ST_MULW;
          end
        end
        ST_MULW: begin
          cnt_q <= '0;
          cz_q  <= '0;
          cx_q  <= {7'd0, la_q, 38'd0};
          cy_q  <= num;
          state_q <= (num == '0) ? ST_DONE : ST_ATAN2;
        end
        ST_ATAN2: begin
          cx_q  <= cx_nx;
          cy_q  <= cy_nx;
          cz_q  <= cz_nx;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (emit) begin
            out_data_q.steering <= steer;
            out_data_q.found    <= tfound_q;
            tfound_q            <= 1'b0;
            tdx_q               <= '0;
            tdy_q               <= '0;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again straight after a transfer");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.steering == 16'sd0)
    else $error("steering non-zero without a target");

  a_steer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_data_o.steering) <= 16'sd25736) &&
                    ($signed(out_data_o.steering) >= -16'sd25736))
    else $error("steering outside +-pi");

endmodule

`default_nettype wire

>>> verif/pure_pursuit_steering_tb.sv
// Self-checking testbench for pure_pursuit_steering: a directed table of waypoint scans
// and register writes, then random scans under varied idling, scored by a local predictor.
// Depends on pps_pkg and the pure_pursuit_steering RTL.
`timescale 1ns / 100ps

module pure_pursuit_steering_tb;
  import pps_pkg::*;

  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned PTS_PER_PHASE = 194;
  localparam int unsigned MAX_SHOWN = 10;
  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;
  localparam longint KINV_Q30 = 652032874;
  localparam longint ARCTAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2};
  localparam int SEND_IDLE [4] = '{0, 56, 0, 23};
  localparam int RECV_STALL [4] = '{0, 0, 56, 23};

  typedef enum logic {ROW_POINT, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [15:0]        val;
    pps_in_t            pt;
    bit                 typed;
    pps_out_t           want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  pps_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  pps_out_t            out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // register shadows and search state
  logic [7:0]         cfg_speed;
  logic [7:0]         cfg_div;
  logic [6:0]         cfg_la_min;
  logic [6:0]         cfg_la_max;
  logic [14:0]        cfg_wheelbase;
  logic signed [15:0] cfg_axle;
  bit                 tgt_found;
  longint             tgt_dx;
  longint             tgt_dy;
  logic [6:0]         la_cur;

  pps_out_t    steer_q [$];
  pps_out_t    head_res;
  int unsigned n_fail;
  int unsigned cycle_cnt;
  int          idle_pct;
  int          stall_pct;

  pure_pursuit_steering u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // vectoring: angle of (x, y) in radians * 2^16
  function automatic longint cordic_atan(input longint y, input longint x);
    longint z;
    longint xs;
    longint ys;
    z = 0;
    if (y == 0) return 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ARCTAN_Q16[i];
      end else begin
        x -= ys; y += xs; z -= ARCTAN_Q16[i];
      end
    end
    return z;
  endfunction

  // rotation: sine in Q.30
  function automatic longint cordic_sin(input longint z);
    longint x;
    longint y;
    longint xs;
    longint ys;
    x = KINV_Q30;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ARCTAN_Q16[i];
      end else begin
        x += ys; y -= xs; z += ARCTAN_Q16[i];
      end
    end
    return y;
  endfunction

  function automatic logic [6:0] lookahead_now();
    int unsigned dv;
    int unsigned q;
    dv = (cfg_div == 0) ? 1 : cfg_div;
    q = cfg_speed / dv;
    if (q < cfg_la_min) q = cfg_la_min;
    else if (q > cfg_la_max) q = cfg_la_max;
    return q[6:0];
  endfunction

  // returns 1 when the point closes a scan and yields a steering result
  function automatic bit track_point(input pps_in_t p, output pps_out_t res);
    longint dx;
    longint py;
    longint lq;
    longint theta;
    longint s_q30;
    longint num;
    longint den;
    longint eta;
    longint mag;
    longint rnd;
    res = '0;
    la_cur = lookahead_now();
    py = longint'($signed(p.point_y));
    if (!tgt_found) begin
      dx = longint'($signed(p.point_x)) - longint'(cfg_axle);
      lq = longint'(la_cur) * 256;
      if (dx > 0 && dx * dx + py * py >= lq * lq) begin
        tgt_found = 1'b1;
        tgt_dx = dx;
        tgt_dy = py;
      end
    end
    if (!p.last_point) return 1'b0;
    if (tgt_found) begin
      theta = cordic_atan(tgt_dy * 16384, tgt_dx * 16384);
      s_q30 = cordic_sin(theta);
      num = 2 * longint'(cfg_wheelbase) * s_q30;
      den = longint'(la_cur) << 38;
      eta = cordic_atan(num, den);
      mag = (eta < 0) ? -eta : eta;
      rnd = (mag + 4) >>> 3;
      if (eta < 0) rnd = -rnd;
      res.steering = rnd[15:0];
      res.found = 1'b1;
    end
    tgt_found = 1'b0;
    tgt_dx = 0;
    tgt_dy = 0;
    return 1'b1;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    case (idx)
      REG_SPEED:       cfg_speed = val[7:0];
      REG_SPEED_DIV:   cfg_div = val[7:0];
      REG_LA_MIN:      cfg_la_min = val[6:0];
      REG_LA_MAX:      cfg_la_max = val[6:0];
      REG_WHEELBASE:   cfg_wheelbase = val[14:0];
      REG_AXLE_OFFSET: cfg_axle = val;
      default: ;
    endcase
  endfunction

  function automatic dir_row_t reg_row(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    dir_row_t r;
    r = '{kind: ROW_REG, idx: idx, val: val, pt: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic dir_row_t pt_row(input int x, input int y, input bit last);
    dir_row_t r;
    r = '{kind: ROW_POINT, idx: '0, val: '0, pt: '0, typed: 1'b0, want: '0};
    r.pt.point_x = x[15:0];
    r.pt.point_y = y[15:0];
    r.pt.last_point = last;
    return r;
  endfunction

  // closing point whose result is known outright
  function automatic dir_row_t pt_known(input int x, input int y, input int steer,
                                        input bit found);
    dir_row_t r;
    r = pt_row(x, y, 1'b1);
    r.typed = 1'b1;
    r.want.steering = steer[15:0];
    r.want.found = found;
    return r;
  endfunction

  // value v in the low w bits, random junk above
  function automatic logic [15:0] with_junk(input int v, input int w);
    int mask;
    mask = (1 << w) - 1;
    return 16'((int'($urandom) & ~mask) | (v & mask));
  endfunction

  function automatic pps_in_t rand_point();
    pps_in_t p;
    int span;
    int cx;
    int cy;
    logic [6:0] la;
    la = lookahead_now();
    span = (la == 0) ? 256 : int'(la) * 256;
    p = '0;
    if ($urandom_range(3) == 0) begin
      p.point_x = 16'($urandom);
      p.point_y = 16'($urandom);
    end else begin
      cx = int'(cfg_axle) + int'($urandom_range(0, 2 * span)) - span / 4;
      cy = int'($urandom_range(0, 2 * span)) - span;
      p.point_x = cx[15:0];
      p.point_y = cy[15:0];
    end
    return p;
  endfunction

  task automatic report_fail(input string what, input pps_out_t want, input pps_out_t got);
    n_fail++;
    if (n_fail <= MAX_SHOWN)
      $display("[%0t] %s: expected steering %0d found %0b, got steering %0d found %0b",
               $realtime, what, $signed(want.steering), want.found,
               $signed(got.steering), got.found);
  endtask

  // valid stays high across back-to-back transfers; lowered on an idle gap or a drain
  task automatic send_point(input pps_in_t p, input bit typed, input pps_out_t want);
    pps_out_t res;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (track_point(p, res)) steer_q.push_back(typed ? want : res);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, val);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (steer_q.size() != 0);
  endtask

  task automatic settle_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic pick_config();
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
    write_reg(REG_SPEED, 16'($urandom));
    write_reg(REG_SPEED_DIV,
              with_junk($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(10), 8));
    write_reg(REG_LA_MIN,
              with_junk($urandom_range(2) == 0 ? $urandom_range(127) : $urandom_range(15), 7));
    write_reg(REG_LA_MAX,
              with_junk($urandom_range(2) == 0 ? $urandom_range(127) : $urandom_range(20), 7));
    write_reg(REG_WHEELBASE, with_junk($urandom_range(32767), 15));
    write_reg(REG_AXLE_OFFSET,
              $urandom_range(1) ? 16'($urandom) : 16'(int'($urandom_range(2000)) - 1000));
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (steer_q.size() == 0) begin
        report_fail("unexpected result", '0, out_data_o);
      end else begin
        head_res = steer_q.pop_front();
        if (out_data_o.steering !== head_res.steering || out_data_o.found !== head_res.found)
          report_fail("steering mismatch", head_res, out_data_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= TIMEOUT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, steer_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab [$];
    pps_in_t  p;
    int       sent;
    int       len;

    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    idle_pct = 0;
    stall_pct = 0;
    n_fail = 0;
    cycle_cnt = 0;
    cfg_speed = SPEED_RST;
    cfg_div = SPEED_DIV_RST;
    cfg_la_min = LA_MIN_RST;
    cfg_la_max = LA_MAX_RST;
    cfg_wheelbase = WHEELBASE_RST;
    cfg_axle = AXLE_OFFSET_RST;
    tgt_found = 1'b0;
    tgt_dx = 0;
    tgt_dy = 0;
    la_cur = '0;

    // reset lookahead 10 m, axle offset 435
    dir_tab = {
      pt_known(-32768, 0, 0, 1'b0),
      pt_row(32767, 32767, 1'b0),
      pt_row(0, -32768, 1'b1),
      pt_known(535, 0, 0, 1'b0),
      pt_row(2995, 0, 1'b1),
      pt_row(2994, 1000, 1'b0),
      pt_row(-100, -5, 1'b1),
      pt_known(435, -32768, 0, 1'b0),
      reg_row(REG_WHEELBASE, 16'h0000),
      pt_known(10000, 5000, 0, 1'b1),
      reg_row(REG_WHEELBASE, 16'h7FFF),
      reg_row(REG_SPEED, 16'h0000),
      reg_row(REG_LA_MIN, 16'h0000),
      reg_row(REG_LA_MAX, 16'h0000),
      pt_row(436, -1, 1'b1),
      reg_row(REG_SPEED, 16'hFFFF),
      reg_row(REG_SPEED_DIV, 16'h0000),
      reg_row(REG_LA_MAX, 16'hFFFF),
      pt_row(32767, 32767, 1'b1),
      reg_row(REG_SPEED, 16'd10),
      reg_row(REG_SPEED_DIV, 16'd1),
      reg_row(REG_LA_MIN, 16'd100),
      reg_row(REG_LA_MAX, 16'd20),
      pt_row(30000, -1000, 1'b1),
      reg_row(REG_AXLE_OFFSET, 16'h8000),
      pt_row(32767, 0, 1'b1),
      reg_row(REG_AXLE_OFFSET, 16'h7FFF),
      pt_known(32767, 32767, 0, 1'b0),
      reg_row(REG_SPARE_LO, 16'hFFFF),
      reg_row(REG_SPARE_HI, 16'h0000),
      pt_known(32767, 0, 0, 1'b0),
      reg_row(REG_SPEED, 16'd50),
      reg_row(REG_SPEED_DIV, 16'd5),
      reg_row(REG_LA_MIN, 16'd5),
      reg_row(REG_LA_MAX, 16'd10),
      reg_row(REG_WHEELBASE, 16'd256),
      reg_row(REG_AXLE_OFFSET, 16'd0),
      pt_row(2000, 0, 1'b0),
      reg_row(REG_LA_MAX, 16'd7),
      pt_row(1900, 300, 1'b0),
      reg_row(REG_LA_MAX, 16'd3),
      pt_row(0, 0, 1'b1)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_REG) begin
        if (r == 0 || dir_tab[r-1].kind != ROW_REG) settle_idle();
        write_reg(dir_tab[r].idx, dir_tab[r].val);
        if (r == dir_tab.size() - 1 || dir_tab[r+1].kind != ROW_REG) cfg_valid_i <= 1'b0;
      end else begin
        send_point(dir_tab[r].pt, dir_tab[r].typed, dir_tab[r].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_idle();
      idle_pct = SEND_IDLE[ph % 4];
      stall_pct <= RECV_STALL[ph % 4];
      pick_config();
      sent = 0;
      while (sent < PTS_PER_PHASE) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          p = rand_point();
          // occasional stray end-of-scan flag
          p.last_point = (k == len - 1) || ($urandom_range(19) == 0);
          send_point(p, 1'b0, '0);
          sent++;
        end
        if ($urandom_range(49) == 0) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
